// ===== hdl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the bitmap set engine: request and result
// item formats, command codes, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int NUM_WORDS_DEF = 8;

  localparam int CMD_W    = 3;
  localparam int MEMBER_W = 8;
  localparam int WIDX_W   = 3;
  localparam int MASK_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int FOUND_W  = 9;

  // popcount of cleared bits runs this many bits per cycle
  localparam int CHUNK    = 8;
  localparam int CHUNK_PW = $clog2(CHUNK + 1);

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MASK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [FOUND_W-1:0] FOUND_NONE = 9'h1FF;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [MEMBER_W-1:0] member;
    logic [WIDX_W-1:0]   word_index;
    logic [MASK_W-1:0]   mask_word;
  } req_t;

  typedef struct packed {
    logic signed [FOUND_W-1:0] found_member;
    logic [COUNT_W-1:0]        member_count;
    logic                      set_empty;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic modify;
    logic cnt_step;
    logic scan_step;
    logic clear_all;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             range_ok;
    logic             cur_nz;
    logic             scan_last;
    logic             count_zero;
    logic             rem_zero;
  } stat_t;

endpackage

// ===== hdl/bitmap_set_engine.sv =====
// ----------------------------------------------------------------------------
// bitmap_set_engine
// Fixed-capacity set of small integers held as a word store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall/req) carries one command per item:
//   add, remove, pop lowest, query, remove mask word, clear all. Response
//   channel (rsp_valid/rsp_stall/rsp) returns exactly one item per request
//   with the popped member (-1 otherwise), the member count and empty flag.
//   One item is in flight at a time; req_stall is high from acceptance until
//   the response is taken.
//   Steps from acceptance to rsp_valid, after decode:
//     query, clear, out-of-range add/remove/mask, pop on empty set: none
//     add, remove: word read, then write back
//     pop: scan to first nonempty word (one flag per cycle), read, write back
//     mask removal: read, write back, cleared-bit count in 8-bit steps
//   The next request is accepted the cycle after the response is taken.
//   Reset clears the word flags and count at once: the set is empty and the
//   block is ready on the first cycle after reset. While rsp_stall is high
//   the response holds and no request is accepted.
// ----------------------------------------------------------------------------
module bitmap_set_engine #(
  parameter int WORD_BITS = bse_pkg::WORD_BITS_DEF,
  parameter int NUM_WORDS = bse_pkg::NUM_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bse_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bse_pkg::rsp_t rsp
);
  import bse_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  bse_datapath #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .ctl  (ctl),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

// ===== hdl/bse_ctrl.sv =====
// ----------------------------------------------------------------------------
// bse_ctrl
// Command sequencer: takes one item at a time, steps the datapath through
// decode, word scan, read-modify-write and cleared-bit count, then holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module bse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  input  bse_pkg::stat_t stat,
  output bse_pkg::ctl_t  ctl
);
  import bse_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_READ   = 7'b0001000,
    ST_MODIFY = 7'b0010000,
    ST_COUNT  = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.cmd)
          CMD_ADD, CMD_REMOVE, CMD_MASK: begin
            state_next = stat.range_ok ? ST_READ : ST_OUT;
          end
          CMD_POP: begin
            state_next = stat.count_zero ? ST_OUT : ST_SCAN;
          end
          CMD_CLEAR: begin
            ctl.clear_all = 1'b1;
            state_next    = ST_OUT;
          end
          default: begin
            state_next = ST_OUT;
          end
        endcase
      end
      ST_SCAN: begin
        // advance to the first word with any member in it
        if (stat.cur_nz) begin
          state_next = ST_READ;
        end else if (stat.scan_last) begin
          state_next = ST_OUT;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_READ: begin
        ctl.mem_rd = 1'b1;
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        ctl.modify = 1'b1;
        state_next = (stat.cmd == CMD_MASK) ? ST_COUNT : ST_OUT;
      end
      ST_COUNT: begin
        if (stat.rem_zero) begin
          state_next = ST_OUT;
        end else begin
          ctl.cnt_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req_stall = (state != ST_IDLE);
  assign rsp_valid = (state == ST_OUT);

endmodule

// ===== hdl/bse_datapath.sv =====
// ----------------------------------------------------------------------------
// bse_datapath
// Word store of the set with per-word nonzero flags, member decode, lowest
// bit finder, running member count and a chunked counter for mask removal.
// ----------------------------------------------------------------------------
module bse_datapath #(
  parameter int WORD_BITS = bse_pkg::WORD_BITS_DEF,
  parameter int NUM_WORDS = bse_pkg::NUM_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  bse_pkg::req_t  req,
  input  bse_pkg::ctl_t  ctl,
  output bse_pkg::stat_t stat,
  output bse_pkg::rsp_t  rsp
);
  import bse_pkg::*;

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] nz;

  logic [CMD_W-1:0]     cmd_r;
  logic [AW-1:0]        addr;
  logic [BW-1:0]        bit_r;
  logic                 range_ok;
  logic [WORD_BITS-1:0] mask_r;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_nz;
  logic [WORD_BITS-1:0] rem;
  logic [COUNT_W-1:0]   count;
  logic [FOUND_W-1:0]   found;

  logic                 dec_hit;
  logic [AW-1:0]        dec_word;
  logic [BW-1:0]        dec_bit;
  logic [WORD_BITS-1:0] old_word;
  logic [WORD_BITS-1:0] bit_oh;
  logic [WORD_BITS-1:0] low_oh;
  logic [BW-1:0]        low_pos;
  logic [WORD_BITS-1:0] new_word;
  logic [CHUNK_PW-1:0]  chunk_pc;

  // member -> word and bit, one range compare per word
  always_comb begin
    dec_hit  = 1'b0;
    dec_word = '0;
    dec_bit  = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (int'(req.member) >= w * WORD_BITS && int'(req.member) < (w + 1) * WORD_BITS) begin
        dec_hit  = 1'b1;
        dec_word = AW'(w);
        dec_bit  = BW'(int'(req.member) - w * WORD_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= req.cmd;
      bit_r  <= dec_bit;
      mask_r <= WORD_BITS'(req.mask_word);
      case (req.cmd)
        CMD_ADD, CMD_REMOVE: begin
          addr     <= dec_word;
          range_ok <= dec_hit;
        end
        CMD_MASK: begin
          addr     <= AW'(req.word_index);
          range_ok <= (int'(req.word_index) < NUM_WORDS);
        end
        default: begin
          addr     <= '0;
          range_ok <= 1'b1;
        end
      endcase
    end else if (ctl.scan_step) begin
      addr <= addr + AW'(1);
    end
  end

  // word store, registered read
  always_ff @(posedge clk) begin
    if (ctl.mem_rd) begin
      rd_data <= mem[addr];
      rd_nz   <= nz[addr];
    end
    if (ctl.modify) begin
      mem[addr] <= new_word;
    end
  end

  // a word whose flag is clear reads as empty
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      nz <= '0;
    end else if (ctl.modify) begin
      nz[addr] <= |new_word;
    end
  end

  always_comb begin
    old_word = rd_nz ? rd_data : '0;
    bit_oh   = WORD_BITS'(1) << bit_r;
    low_oh   = old_word & (~old_word + WORD_BITS'(1));
    low_pos  = '0;
    for (int k = 0; k < BW; k++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (((j >> k) & 1) == 1) begin
          low_pos[k] = low_pos[k] | low_oh[j];
        end
      end
    end
    case (cmd_r)
      CMD_ADD:    new_word = old_word | bit_oh;
      CMD_REMOVE: new_word = old_word & ~bit_oh;
      CMD_POP:    new_word = old_word & ~low_oh;
      CMD_MASK:   new_word = old_word & ~mask_r;
      default:    new_word = old_word;
    endcase
  end

  always_comb begin
    chunk_pc = '0;
    for (int i = 0; i < CHUNK; i++) begin
      chunk_pc = chunk_pc + CHUNK_PW'(rem[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.modify) begin
      rem <= old_word & mask_r;
    end else if (ctl.cnt_step) begin
      rem <= rem >> CHUNK;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      found <= FOUND_NONE;
    end else if (ctl.modify && cmd_r == CMD_POP) begin
      found <= FOUND_W'(int'(addr) * WORD_BITS + int'(low_pos));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      count <= '0;
    end else if (ctl.modify) begin
      case (cmd_r)
        CMD_ADD:    count <= count + (old_word[bit_r] ? COUNT_W'(0) : COUNT_W'(1));
        CMD_REMOVE: count <= count - (old_word[bit_r] ? COUNT_W'(1) : COUNT_W'(0));
        CMD_POP:    count <= count - COUNT_W'(1);
        default:    count <= count;
      endcase
    end else if (ctl.cnt_step) begin
      count <= count - COUNT_W'(chunk_pc);
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.range_ok   = range_ok;
  assign stat.cur_nz     = nz[addr];
  assign stat.scan_last  = (addr == AW'(NUM_WORDS - 1));
  assign stat.count_zero = (count == '0);
  assign stat.rem_zero   = (rem == '0);

  assign rsp.found_member = found;
  assign rsp.member_count = count;
  assign rsp.set_empty    = (count == '0);

endmodule

// ===== hdl/bse_checker.sv =====
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks for the bitmap set engine, bound to the top level.
// ----------------------------------------------------------------------------
module bse_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input bse_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input bse_pkg::rsp_t rsp
);
  import bse_pkg::*;

  // a stalled response item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one item in flight: no request taken while a response is pending
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request accepted with response pending");

  // the cycle after a request is taken no response is shown yet
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !rsp_valid)
    else $error("response shown one cycle after accept");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.set_empty == (rsp.member_count == '0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.member_count <= COUNT_W'(256)))
    else $error("member count out of range");

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (.*);
